>>> rtl/core/tdpt_pkg.sv
// tdpt_pkg: shared types and constants of the trial-division prime test
// no dependencies; imported by tdpt_value_if, the remainder unit and the top level
`default_nettype none

package tdpt_pkg;

	// field widths
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned MAG_W   = VALUE_W - 1;
	localparam int unsigned DIV_W   = 16;
	localparam int unsigned SQ_W    = 32;

	// divisor sweep: odd divisors from three up to the cap
	localparam logic [DIV_W-1:0] DIV_START = 16'd3;
	localparam logic [DIV_W-1:0] DIV_CAP   = 16'd46340;
	localparam logic [SQ_W-1:0]  SQ_START  = 32'd9;

	// remainder unit: quotient bits retired per cycle and rounds per item
	localparam int unsigned RADIX_STEPS = 4;
	localparam int unsigned DVD_W       = 32;
	localparam int unsigned ROUNDS      = DVD_W / RADIX_STEPS;
	localparam int unsigned RND_W       = $clog2(ROUNDS);

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_WAIT,
		ST_FIN
	} tdpt_state_t;

	// request to the remainder unit
	typedef struct packed {
		logic             start;
		logic [MAG_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} rem_req_t;

	// status from the remainder unit
	typedef struct packed {
		logic busy;
		logic done;
		logic zero;
	} rem_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/tdpt_ifs.sv
// tdpt_ifs: valid/ready channel interfaces for the value and prime beats
// depends on tdpt_pkg for field widths
`default_nettype none

interface tdpt_value_if;
	import tdpt_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface tdpt_prime_if;
	logic valid;
	logic ready;
	logic prime;

	modport source (output valid, output prime, input ready);
	modport sink   (input valid, input prime, output ready);
endinterface

`default_nettype wire

>>> rtl/core/trial_division_prime_test.sv
// trial_division_prime_test: top level, sequencer around one shared remainder unit
// depends on tdpt_pkg, tdpt_ifs (tdpt_value_if, tdpt_prime_if), tdpt_rem_unit
//
//  channel    dir  handshake      payload
//  value_ch   in   valid/ready    value  (32 bit, signed)
//  prime_ch   out  valid/ready    prime  (1 bit)
//
// one item at a time; value_ch.ready is high only while the sequencer is idle
// trivial values (negative, 0, 1, 2, even) skip the divisor sweep and go straight to the result
// otherwise each odd trial divisor takes a bound check and 8 rounds of the remainder
// unit; the item ends at the first divisor that divides or when the sweep runs out
// a waiting result on prime_ch holds the sequencer before it can load the next
// reset clears the sequencer, the output valid and the remainder unit's control; datapath registers are not reset
`default_nettype none

module trial_division_prime_test (
	input  wire          clk,
	input  wire          arst_n,
	tdpt_value_if.sink   value_ch,
	tdpt_prime_if.source prime_ch
);
	import tdpt_pkg::*;

	tdpt_state_t      state_q, state_nxt;
	logic [MAG_W-1:0] v_q;
	logic [DIV_W-1:0] d_q;
	logic [SQ_W-1:0]  sq_q;
	logic             res_q;
	logic             ovalid_q;
	logic             oprime_q;

	rem_req_t         rem_req;
	rem_stat_t        rem_stat;

	logic             in_beat;
	logic             out_beat;
	logic             load_out;
	logic             trivial;
	logic             trivial_res;
	logic             sweep_end;

	tdpt_rem_unit u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.stat   (rem_stat)
	);

	// classify the incoming value
	always_comb begin
		trivial     = 1'b1;
		trivial_res = 1'b0;
		if (value_ch.value[VALUE_W-1] || value_ch.value[VALUE_W-1:1] == '0) begin
			trivial_res = 1'b0;
		end else if (value_ch.value == VALUE_W'(2)) begin
			trivial_res = 1'b1;
		end else if (!value_ch.value[0]) begin
			trivial_res = 1'b0;
		end else begin
			trivial = 1'b0;
		end
	end

	// divisors run out once past the cap or the square exceeds the value
	assign sweep_end = (d_q > DIV_CAP) || (sq_q > {{(SQ_W-MAG_W){1'b0}}, v_q});

	assign in_beat  = value_ch.valid && value_ch.ready;
	assign out_beat = prime_ch.valid && prime_ch.ready;

	// sequencer: next state and strobes
	always_comb begin
		state_nxt        = state_q;
		value_ch.ready   = 1'b0;
		rem_req.start    = 1'b0;
		rem_req.dividend = v_q;
		rem_req.divisor  = d_q;
		load_out         = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				value_ch.ready = 1'b1;
				if (value_ch.valid) begin
					state_nxt = trivial ? ST_FIN : ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sweep_end) begin
					state_nxt = ST_FIN;
				end else begin
					rem_req.start = 1'b1;
					state_nxt     = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (rem_stat.done) begin
					state_nxt = rem_stat.zero ? ST_FIN : ST_CHECK;
				end
			end
			ST_FIN: begin
				if (!ovalid_q || prime_ch.ready) begin
					load_out  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// working registers: value, divisor, divisor squared, verdict
	always_ff @(posedge clk) begin
		if (in_beat) begin
			v_q   <= value_ch.value[MAG_W-1:0];
			d_q   <= DIV_START;
			sq_q  <= SQ_START;
			res_q <= trivial_res;
		end else if (state_q == ST_CHECK && sweep_end) begin
			res_q <= 1'b1;
		end else if (state_q == ST_WAIT && rem_stat.done) begin
			if (rem_stat.zero) begin
				res_q <= 1'b0;
			end else begin
				d_q  <= d_q + DIV_W'(2);
				sq_q <= sq_q + SQ_W'({d_q, 2'b00}) + SQ_W'(4);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (load_out) begin
			ovalid_q <= 1'b1;
		end else if (out_beat) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			oprime_q <= res_q;
		end
	end

	assign prime_ch.valid = ovalid_q;
	assign prime_ch.prime = oprime_q;

	// trial divisors are always odd
	a_div_odd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHECK |-> d_q[0])
		else $error("even trial divisor");

	// the running square tracks the divisor
	a_sq_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHECK |-> sq_q == SQ_W'(d_q) * SQ_W'(d_q))
		else $error("divisor square out of step");

	// the remainder unit is started only when free
	a_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		rem_req.start |-> !rem_stat.busy)
		else $error("remainder unit started while busy");

	// a division result arrives only while the sequencer waits for it
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		rem_stat.done |-> state_q == ST_WAIT)
		else $error("unexpected remainder result");

endmodule

`default_nettype wire

>>> rtl/core/tdpt_rem_unit.sv
// tdpt_rem_unit: iterative remainder unit, 4 restoring steps per cycle
// depends on tdpt_pkg (rem_req_t, rem_stat_t, widths)
`default_nettype none

module tdpt_rem_unit (
	input  wire                 clk,
	input  wire                 arst_n,
	input  tdpt_pkg::rem_req_t  req,
	output tdpt_pkg::rem_stat_t stat
);
	import tdpt_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic             zero_q;
	logic [RND_W-1:0] rnd_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] div_q;

	logic [DVD_W-1:0] dvd_nxt;
	logic [DIV_W-1:0] rem_nxt;
	logic             last_rnd;

	// one round: shift in a dividend bit and conditionally subtract, four times
	always_comb begin
		logic [DIV_W:0] part;
		dvd_nxt = dvd_q;
		rem_nxt = rem_q;
		for (int i = 0; i < RADIX_STEPS; i++) begin
			part    = {rem_nxt, dvd_nxt[DVD_W-1]};
			dvd_nxt = {dvd_nxt[DVD_W-2:0], 1'b0};
			if (part >= {1'b0, div_q}) begin
				part = part - {1'b0, div_q};
			end
			rem_nxt = part[DIV_W-1:0];
		end
	end

	assign last_rnd = (rnd_q == RND_W'(ROUNDS - 1));

	// control: busy flag, round counter, done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + RND_W'(1);
				if (last_rnd) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: dividend shifter, partial remainder, divisor
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			dvd_q <= {{(DVD_W-MAG_W){1'b0}}, req.dividend};
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			dvd_q <= dvd_nxt;
			rem_q <= rem_nxt;
			if (last_rnd) begin
				zero_q <= (rem_nxt == '0);
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign stat.zero = zero_q;

	// partial remainder always stays below the divisor
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < div_q)
		else $error("partial remainder not below divisor");

	// done rises in the cycle after the last round
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && last_rnd) |=> (done_q && !busy_q))
		else $error("done missing after last round");

	// a done pulse never comes while a division is running
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("done while busy");

endmodule

`default_nettype wire
